### design/sir_pkg.sv
`default_nettype none

package sir_pkg;

    // Ring geometry and timestamp width.
    localparam int SLOTS     = 8;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TIME_BITS = 32;

    // Port widths of the result fields.
    localparam int OUT_SLOT_BITS = 3;
    localparam int FRAC_BITS     = 16;
    localparam int BLEND_BITS    = FRAC_BITS + 1;
    localparam int STEP_BITS     = $clog2(FRAC_BITS);

    localparam logic [BLEND_BITS-1:0] BLEND_ONE = BLEND_BITS'(1) << FRAC_BITS;

    // Request operation codes.
    localparam logic OP_COMMIT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [SLOT_BITS-1:0]     t_slot;
    typedef logic [OUT_SLOT_BITS-1:0] t_out_slot;
    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [BLEND_BITS-1:0]    t_blend;

    // Next slot around the ring.
    function automatic t_slot slot_inc(input t_slot s);
        return (s == SLOT_BITS'(SLOTS - 1)) ? '0 : s + SLOT_BITS'(1);
    endfunction

    // Previous slot around the ring.
    function automatic t_slot slot_dec(input t_slot s);
        return (s == '0) ? SLOT_BITS'(SLOTS - 1) : s - SLOT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

### design/snapshot_interpolation_ring_unit.sv
`default_nettype none
// A commit goes from acceptance straight to S_DONE, which loads the result. A query
// fetches and compares each slot examined (up to 8), fetches the newer slot, runs
// restoring division when a fraction is needed and then loads the result in S_DONE,
// which waits while a stalled result holds the output register. One request at a time:
// o_stall holds off the next until the result is loaded. Synchronous active-low
// reset empties the ring (all timestamps read as zero) and returns the pointer to slot 0.
module snapshot_interpolation_ring_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire                           i_operation,
    input  wire  [sir_pkg::TIME_BITS-1:0] i_commit_time,
    input  wire  [sir_pkg::TIME_BITS-1:0] i_query_time,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic                          o_found,
    output logic [sir_pkg::OUT_SLOT_BITS-1:0] o_older_slot,
    output logic [sir_pkg::OUT_SLOT_BITS-1:0] o_newer_slot,
    output logic [sir_pkg::BLEND_BITS-1:0]    o_blend,
    output logic [sir_pkg::OUT_SLOT_BITS-1:0] o_written_slot
);
    import sir_pkg::*;

    // The sequencer walks the ring backward, one slot per S_FETCH/S_CMP pair, since each
    // timestamp comes out of the registered read port in the cycle after its address is set.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CMP,
        S_FETCH_NX,
        S_TB,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Ring bookkeeping.
    t_slot              r_wp, n_wp;
    logic [SLOTS-1:0]   r_slot_valid, n_slot_valid;
    t_slot              r_addr, n_addr;
    t_slot              r_cnt, n_cnt;

    // Timestamp memory. An entry that was never written reads as zero through its
    // valid bit, which matches the cleared ring after reset.
    t_time r_mem [SLOTS];
    t_time r_rd_data;
    logic  mem_we;

    // Working registers of the current request.
    t_time              r_q, n_q;
    t_time              r_ta, n_ta;
    t_time              r_rem, n_rem;
    t_time              r_den, n_den;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic               r_found, n_found;
    t_slot              r_older, n_older;
    t_slot              r_newer, n_newer;
    t_slot              r_wr_slot, n_wr_slot;
    t_blend             r_quo, n_quo;

    // Output register, which frees the sequencer while a result waits.
    logic               r_o_valid, n_o_valid;
    logic               r_o_found, n_o_found;
    t_out_slot          r_o_older, n_o_older;
    t_out_slot          r_o_newer, n_o_newer;
    t_blend             r_o_blend, n_o_blend;
    t_out_slot          r_o_written, n_o_written;

    logic               in_accept;
    logic [TIME_BITS:0] rem2;
    logic [TIME_BITS:0] rem_sub;
    logic               rem_ge;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign mem_we    = in_accept && (i_operation == OP_COMMIT);

    // One restoring division step: shift the remainder, try the subtraction.
    assign rem2    = {r_rem, 1'b0};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign rem_ge  = (rem2 >= {1'b0, r_den});

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_slot_valid = r_slot_valid;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_q          = r_q;
        n_ta         = r_ta;
        n_rem        = r_rem;
        n_den        = r_den;
        n_step       = r_step;
        n_found      = r_found;
        n_older      = r_older;
        n_newer      = r_newer;
        n_wr_slot    = r_wr_slot;
        n_quo        = r_quo;
        n_o_valid    = r_o_valid;
        n_o_found    = r_o_found;
        n_o_older    = r_o_older;
        n_o_newer    = r_o_newer;
        n_o_blend    = r_o_blend;
        n_o_written  = r_o_written;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_found = 1'b0;
                    n_older = '0;
                    n_newer = '0;
                    n_quo   = '0;
                    if (i_operation == OP_COMMIT) begin
                        n_wr_slot            = r_wp;
                        n_slot_valid[r_wp]   = 1'b1;
                        n_wp                 = slot_inc(r_wp);
                        n_state              = S_DONE;
                    end else begin
                        // Start from the newest slot and walk backward.
                        n_wr_slot = '0;
                        n_q       = i_query_time;
                        n_addr    = slot_dec(r_wp);
                        n_cnt     = '0;
                        n_state   = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data <= r_q) begin
                    n_ta    = r_rd_data;
                    n_older = r_addr;
                    n_addr  = slot_inc(r_addr);
                    n_state = S_FETCH_NX;
                end else if (r_cnt == SLOT_BITS'(SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = slot_dec(r_addr);
                    n_cnt   = r_cnt + SLOT_BITS'(1);
                    n_state = S_FETCH;
                end
            end
            S_FETCH_NX: begin
                n_state = S_TB;
            end
            S_TB: begin
                n_found = 1'b1;
                n_newer = r_addr;
                n_rem   = r_q - r_ta;
                n_den   = r_rd_data - r_ta;
                n_step  = '0;
                if (r_rd_data <= r_ta) begin
                    // Equal stamps or newer before older give no fraction.
                    n_quo   = '0;
                    n_state = S_DONE;
                end else if (r_q >= r_rd_data) begin
                    // At or past the newer snapshot the fraction saturates.
                    n_quo   = BLEND_ONE;
                    n_state = S_DONE;
                end else begin
                    n_quo   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = rem_ge ? rem_sub[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
                n_quo  = {r_quo[BLEND_BITS-2:0], rem_ge};
                n_step = r_step + STEP_BITS'(1);
                if (r_step == STEP_BITS'(FRAC_BITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid   = 1'b1;
                    n_o_found   = r_found;
                    n_o_older   = OUT_SLOT_BITS'(r_older);
                    n_o_newer   = OUT_SLOT_BITS'(r_newer);
                    n_o_blend   = r_quo;
                    n_o_written = OUT_SLOT_BITS'(r_wr_slot);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_cnt       <= n_cnt;
        r_q         <= n_q;
        r_ta        <= n_ta;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_step      <= n_step;
        r_found     <= n_found;
        r_older     <= n_older;
        r_newer     <= n_newer;
        r_wr_slot   <= n_wr_slot;
        r_quo       <= n_quo;
        r_o_found   <= n_o_found;
        r_o_older   <= n_o_older;
        r_o_newer   <= n_o_newer;
        r_o_blend   <= n_o_blend;
        r_o_written <= n_o_written;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_slot_valid <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_slot_valid <= n_slot_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    // Timestamp memory: one write port for commits, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_commit_time;
        end
        r_rd_data <= r_slot_valid[r_addr] ? r_mem[r_addr] : '0;
    end

    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_older_slot   = r_o_older;
    assign o_newer_slot   = r_o_newer;
    assign o_blend        = r_o_blend;
    assign o_written_slot = r_o_written;

    // A result with no match carries no slots and no fraction.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_older_slot == '0 && o_newer_slot == '0 &&
                                   o_blend == '0))
        else $error("unmatched result carries nonzero fields");

    // The newer slot always follows the older one around the ring.
    a_newer_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |->
            (o_newer_slot == ((o_older_slot == OUT_SLOT_BITS'(SLOTS - 1)) ?
                              OUT_SLOT_BITS'(0) : o_older_slot + OUT_SLOT_BITS'(1))))
        else $error("newer slot does not follow older slot");

    // The fraction never exceeds one.
    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_blend <= BLEND_ONE))
        else $error("blend fraction above one");

    // The divider only runs with a proper fraction.
    a_div_proper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    // A commit advances the write pointer by one slot with wrap.
    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operation == OP_COMMIT) |=> (r_wp == slot_inc($past(r_wp))))
        else $error("write pointer did not advance on commit");

endmodule
`default_nettype wire
